FILE: rtl/core/linear_audio_resampler_unit_assert.svh
// assertion helpers for the resampler
`ifndef LINEAR_AUDIO_RESAMPLER_UNIT_ASSERT_SVH
`define LINEAR_AUDIO_RESAMPLER_UNIT_ASSERT_SVH

// check under reset qualification
`define LAR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("resampler assertion failed");

// check at every edge, reset included
`define LAR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("resampler assertion failed");

`endif

FILE: rtl/core/lar_pkg.sv
`default_nettype none
package lar_pkg;

	localparam logic [19:0] ONE_POS   = 20'h10000;
	localparam logic [18:0] MIN_RATIO = 19'd1024;
	localparam logic [5:0]  LAST_IDX  = 6'd63;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PUSH  = 1'b1;

	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_RATIO     = 3'd1;
	localparam logic [2:0] REG_START_POS = 3'd2;
	localparam logic [2:0] REG_OUT_COUNT = 3'd3;
	localparam logic [2:0] REG_HIST0     = 3'd4;
	localparam logic [2:0] REG_HIST1     = 3'd5;
	localparam logic [2:0] REG_HIST2     = 3'd6;
	localparam logic [2:0] REG_HIST3     = 3'd7;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] sample;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [15:0]        phase;
		logic               block_end;
		logic               last;
	} res_t;

	typedef struct packed {
		logic               mode;
		logic [18:0]        ratio;
		logic [15:0]        start_pos;
		logic [15:0]        out_count;
		logic signed [15:0] hist0;
		logic signed [15:0] hist1;
		logic signed [15:0] hist2;
		logic signed [15:0] hist3;
	} cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/lar_fifo.sv
`default_nettype none
module lar_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/lar_front.sv
`default_nettype none
module lar_front #(
	parameter int CMD_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               req_type,
	input  wire logic signed [15:0] in_sample,
	output lar_pkg::cmd_t           cmd,
	output logic                    cmd_valid,
	input  wire logic               cmd_pop
);

	lar_pkg::cmd_t                       in_cmd;
	logic [$bits(lar_pkg::cmd_t)-1:0]    head;
	logic                                q_empty;

	// classify the word
	always_comb begin
		in_cmd.kind   = req_type ? lar_pkg::CMD_PUSH : lar_pkg::CMD_START;
		in_cmd.sample = in_sample;
	end

	lar_fifo #(
		.WIDTH($bits(lar_pkg::cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(in_cmd),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_data(head),
		.empty  (q_empty)
	);

	assign cmd       = lar_pkg::cmd_t'(head);
	assign cmd_valid = !q_empty;

endmodule
`default_nettype wire

FILE: rtl/core/lar_back.sv
`default_nettype none
module lar_back #(
	parameter int OUT_DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lar_pkg::cfg_t cfg,
	input  wire lar_pkg::cmd_t cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_pop,
	output lar_pkg::res_t      res,
	output logic               res_empty,
	input  wire logic          res_pop
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic               state_q;
	logic signed [15:0] hist_q [4];
	logic [19:0]        phase_q;
	logic [15:0]        done_q;
	logic               ended_q;
	logic [5:0]         n_q;

	logic [18:0]        eff_ratio;
	logic [19:0]        next_phase;
	logic [15:0]        done_inc;
	logic               at_end;
	logic               cont;
	logic signed [16:0] diff;
	logic signed [16:0] frac;
	logic signed [33:0] prod;
	logic signed [16:0] blend_w;
	logic               res_full;
	logic               res_wr;
	lar_pkg::res_t      res_wdata;
	logic [$bits(lar_pkg::res_t)-1:0] res_head;

	assign eff_ratio  = (cfg.ratio < lar_pkg::MIN_RATIO) ? lar_pkg::MIN_RATIO : cfg.ratio;
	assign next_phase = phase_q + {1'b0, eff_ratio};
	assign done_inc   = done_q + 16'd1;
	assign at_end     = (done_inc >= cfg.out_count);
	assign cont       = !ended_q && (phase_q < lar_pkg::ONE_POS);

	// s0 + floor((s1 - s0) * frac / 2^16)
	assign diff    = {hist_q[1][15], hist_q[1]} - {hist_q[0][15], hist_q[0]};
	assign frac    = {1'b0, phase_q[15:0]};
	assign prod    = diff * frac;
	assign blend_w = {hist_q[0][15], hist_q[0]} + prod[32:16];

	always_comb begin
		cmd_pop   = 1'b0;
		res_wr    = 1'b0;
		res_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				cmd_pop = cmd_valid && !res_full;
				if (cmd.kind == lar_pkg::CMD_PUSH && !ended_q && !cfg.mode) begin
					res_wr              = cmd_pop;
					res_wdata.sample    = cmd.sample;
					res_wdata.phase     = cfg.start_pos;
					res_wdata.block_end = at_end;
					res_wdata.last      = 1'b1;
				end
			end
			ST_EMIT: begin
				res_wr              = cont && !res_full;
				res_wdata.sample    = blend_w[15:0];
				res_wdata.phase     = phase_q[15:0];
				res_wdata.block_end = at_end;
				res_wdata.last      = at_end || (next_phase >= lar_pkg::ONE_POS) ||
				                      (n_q == lar_pkg::LAST_IDX);
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 4; i++) begin
				hist_q[i] <= '0;
			end
			phase_q <= lar_pkg::ONE_POS;
			done_q  <= '0;
			ended_q <= 1'b1;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						n_q <= '0;
						if (cmd.kind == lar_pkg::CMD_START) begin
							hist_q[0] <= cfg.hist0;
							hist_q[1] <= cfg.hist1;
							hist_q[2] <= cfg.hist2;
							hist_q[3] <= cfg.hist3;
							phase_q   <= {4'b0, cfg.start_pos} + {1'b0, eff_ratio};
							done_q    <= '0;
							ended_q   <= (cfg.out_count == '0);
							if (cfg.mode) begin
								state_q <= ST_EMIT;
							end
						end else if (!ended_q) begin
							hist_q[0] <= hist_q[1];
							hist_q[1] <= hist_q[2];
							hist_q[2] <= hist_q[3];
							hist_q[3] <= cmd.sample;
							if (cfg.mode) begin
								if (phase_q >= lar_pkg::ONE_POS) begin
									phase_q <= phase_q - lar_pkg::ONE_POS;
								end
								state_q <= ST_EMIT;
							end else begin
								done_q  <= done_inc;
								ended_q <= at_end;
							end
						end
					end
				end
				ST_EMIT: begin
					if (!cont) begin
						state_q <= ST_IDLE;
					end else if (!res_full) begin
						done_q  <= done_inc;
						ended_q <= at_end;
						phase_q <= next_phase;
						n_q     <= n_q + 6'd1;
						if (res_wdata.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	lar_fifo #(
		.WIDTH($bits(lar_pkg::res_t)),
		.DEPTH(OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_wr),
		.wr_data(res_wdata),
		.full   (res_full),
		.rd_en  (res_pop),
		.rd_data(res_head),
		.empty  (res_empty)
	);

	assign res = lar_pkg::res_t'(res_head);

endmodule
`default_nettype wire

FILE: rtl/core/linear_audio_resampler_unit.sv
// Path: a pass-through word goes through the command queue into the result queue;
//   in linear mode the popped word starts the emit state, which writes its results.
// Flow: a linear-mode word holds the emission unit until its last result (64 at most),
//   and no command is popped meanwhile; the one-result-per-cycle blend loop runs while
//   the result queue is not full.
// Reset: arst_n clears both queues, the history and counters, and loads register defaults.
`default_nettype none
module linear_audio_resampler_unit #(
	parameter int CMD_DEPTH = 4,
	parameter int OUT_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               req_type,
	input  wire logic signed [15:0] in_sample,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [15:0]      out_sample,
	output logic [15:0]             out_phase,
	output logic                    block_end,
	output logic                    last,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [18:0]        cfg_wdata
);

	lar_pkg::cfg_t cfg_q;
	lar_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_pop;
	lar_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= 1'b1;
			cfg_q.ratio     <= 19'h10000;
			cfg_q.start_pos <= '0;
			cfg_q.out_count <= 16'd1;
			cfg_q.hist0     <= '0;
			cfg_q.hist1     <= '0;
			cfg_q.hist2     <= '0;
			cfg_q.hist3     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lar_pkg::REG_MODE:      cfg_q.mode      <= cfg_wdata[0];
				lar_pkg::REG_RATIO:     cfg_q.ratio     <= cfg_wdata;
				lar_pkg::REG_START_POS: cfg_q.start_pos <= cfg_wdata[15:0];
				lar_pkg::REG_OUT_COUNT: cfg_q.out_count <= cfg_wdata[15:0];
				lar_pkg::REG_HIST0:     cfg_q.hist0     <= cfg_wdata[15:0];
				lar_pkg::REG_HIST1:     cfg_q.hist1     <= cfg_wdata[15:0];
				lar_pkg::REG_HIST2:     cfg_q.hist2     <= cfg_wdata[15:0];
				lar_pkg::REG_HIST3:     cfg_q.hist3     <= cfg_wdata[15:0];
				default:                cfg_q.mode      <= cfg_q.mode;
			endcase
		end
	end

	lar_front #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.in_sample(in_sample),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop)
	);

	lar_back #(
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.res      (res),
		.res_empty(empty),
		.res_pop  (pop)
	);

	assign out_sample = res.sample;
	assign out_phase  = res.phase;
	assign block_end  = res.block_end;
	assign last       = res.last;

endmodule
`default_nettype wire

FILE: rtl/core/lar_checker.sv
`default_nettype none
`include "linear_audio_resampler_unit_assert.svh"
module lar_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               full,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic signed [15:0] out_sample,
	input wire logic [15:0]        out_phase,
	input wire logic               block_end,
	input wire logic               last
);

	// hold a waiting word until taken
	`LAR_ASSERT(a_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(out_sample) && $stable(out_phase) && $stable(last)))

	// block end closes the burst of its word
	`LAR_ASSERT(a_end_last, clk, arst_n, (!empty && block_end) |-> last)

	// both queues drained out of reset
	`LAR_ASSERT_ALWAYS(a_rst, clk, $rose(arst_n) |-> (empty && !full))

endmodule

bind linear_audio_resampler_unit lar_checker u_lar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.out_sample(out_sample),
	.out_phase (out_phase),
	.block_end (block_end),
	.last      (last)
);
`default_nettype wire
